>>> hw/rtl/ati_pkg.sv
// Shared constants and control/status types of the interpolated acoustic tensor unit.
package ati_pkg;

	localparam int DIM_DEFAULT  = 3;
	localparam int IDX_W        = 2;
	localparam int ACC_ROWS     = 3;
	localparam int ACC_DEPTH    = 9;
	localparam int SLOT_W       = 4;
	localparam int ACC_W        = 64;
	localparam int STIFF_W      = 24;
	localparam int NORM_W       = 16;
	localparam int FRAC_W       = 16;
	localparam int VAL_W        = 32;
	localparam int INTERP_SHIFT = 15;
	localparam int OUT_SHIFT    = 28;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load;      // capture the accepted item
		logic mul1;      // h*diff and n_k*n_m
		logic mul2;      // contraction products, read accumulator slot
		logic acc_wr;    // write back updated accumulators
		logic emit_rd;   // read accumulator slot of the emit counter
		logic emit_cvt;  // round, saturate and load result registers
		logic emit_adv;  // advance emit counter
	} ati_cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic in_range;   // all indexes below DIM
		logic last;       // captured last flag
		logic emit_done;  // emit counter is on the final entry
	} ati_sts_t;

endpackage

>>> hw/rtl/acoustic_tensor_interpolated_unit.sv
// Top level of the interpolated acoustic tensor unit.
// Takes one stiffness element at a time; after acceptance it passes through two multiply stages
// and the write-back before the next acceptance (only the first stage when an index is out of range).
// An element with the last flag then emits DIM*DIM entries; each entry is read from its
// accumulator slot, rounded and saturated, then presented until taken, and the next entry
// follows once the previous one is taken.
// Reset (arst_n low) returns the sequencer to idle and marks all accumulators as zero.
module acoustic_tensor_interpolated_unit
	import ati_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      first_element,
	input  logic                      last_element,
	input  logic [IDX_W-1:0]          idx_i,
	input  logic [IDX_W-1:0]          idx_l,
	input  logic [IDX_W-1:0]          idx_k,
	input  logic [IDX_W-1:0]          idx_m,
	input  logic signed [STIFF_W-1:0] stiff_alpha,
	input  logic signed [STIFF_W-1:0] stiff_beta,
	input  logic signed [NORM_W-1:0]  normal_x,
	input  logic signed [NORM_W-1:0]  normal_y,
	input  logic signed [NORM_W-1:0]  normal_z,
	input  logic [FRAC_W-1:0]         phase_fraction,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic signed [VAL_W-1:0]   k_value,
	output logic signed [VAL_W-1:0]   dk_value,
	output logic                      last_result
);

	ati_cmd_t cmd;
	ati_sts_t sts;

	// Sequencer
	ati_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	ati_dp #(
		.DIM (DIM)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.first_element  (first_element),
		.last_element   (last_element),
		.idx_i          (idx_i),
		.idx_l          (idx_l),
		.idx_k          (idx_k),
		.idx_m          (idx_m),
		.stiff_alpha    (stiff_alpha),
		.stiff_beta     (stiff_beta),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.normal_z       (normal_z),
		.phase_fraction (phase_fraction),
		.out_row        (out_row),
		.out_col        (out_col),
		.k_value        (k_value),
		.dk_value       (dk_value),
		.last_result    (last_result)
	);

`ifndef SYNTHESIS
	// No item is taken while results are pending
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item accepted while result pending");

	// One item at a time: acceptance is followed by a busy cycle
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("back-to-back item acceptance");

	// The final entry of a run is the last row and column
	a_last_entry_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_result) |->
		(out_row == IDX_W'(DIM - 1)) && (out_col == IDX_W'(DIM - 1)))
		else $error("last_result on wrong entry");

	// The run ends after its final entry is taken
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_result) |=> !out_valid)
		else $error("result after final entry");
`endif

endmodule

>>> hw/rtl/ati_ctrl.sv
// Sequencer of the interpolated acoustic tensor unit.
module ati_ctrl
	import ati_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  ati_sts_t sts,
	output ati_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PROD1 = 7'b0000010,
		ST_PROD2 = 7'b0000100,
		ST_ACCUM = 7'b0001000,
		ST_RD    = 7'b0010000,
		ST_CVT   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} ati_state_t;

	ati_state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROD1;
				end
			end
			ST_PROD1: begin
				cmd.mul1 = 1'b1;
				if (sts.in_range) begin
					state_d = ST_PROD2;
				end else if (sts.last) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PROD2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.acc_wr = 1'b1;
				state_d    = sts.last ? ST_RD : ST_IDLE;
			end
			ST_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_CVT;
			end
			ST_CVT: begin
				cmd.emit_cvt = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.emit_adv = 1'b1;
					state_d      = sts.emit_done ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/ati_dp.sv
// Datapath of the interpolated acoustic tensor unit: products, accumulators, result rounding.
module ati_dp
	import ati_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ati_cmd_t                  cmd,
	output ati_sts_t                  sts,
	input  logic                      first_element,
	input  logic                      last_element,
	input  logic [IDX_W-1:0]          idx_i,
	input  logic [IDX_W-1:0]          idx_l,
	input  logic [IDX_W-1:0]          idx_k,
	input  logic [IDX_W-1:0]          idx_m,
	input  logic signed [STIFF_W-1:0] stiff_alpha,
	input  logic signed [STIFF_W-1:0] stiff_beta,
	input  logic signed [NORM_W-1:0]  normal_x,
	input  logic signed [NORM_W-1:0]  normal_y,
	input  logic signed [NORM_W-1:0]  normal_z,
	input  logic [FRAC_W-1:0]         phase_fraction,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic signed [VAL_W-1:0]   k_value,
	output logic signed [VAL_W-1:0]   dk_value,
	output logic                      last_result
);

	localparam logic [IDX_W-1:0] DIM_IDX  = IDX_W'(DIM);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);
	localparam int DIFF_W = STIFF_W + 1;
	localparam int HD_W   = FRAC_W + 1 + DIFF_W;
	localparam int RS_W   = HD_W - INTERP_SHIFT;
	localparam int INT_W  = RS_W + 1;
	localparam int NN_W   = 2 * NORM_W;
	localparam int PK_W   = NN_W + INT_W;
	localparam int PD_W   = NN_W + DIFF_W;

	// Captured item
	logic                      last_q;
	logic [IDX_W-1:0]          idx_i_q, idx_l_q, idx_k_q, idx_m_q;
	logic signed [STIFF_W-1:0] alpha_q, beta_q;
	logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;
	logic [FRAC_W-1:0]         frac_q;

	// Pipeline registers
	logic signed [HD_W-1:0]    hd_s1;
	logic signed [NN_W-1:0]    nn_s1;
	logic signed [DIFF_W-1:0]  diff_s1;
	logic signed [STIFF_W-1:0] beta_s1;
	logic signed [PK_W-1:0]    pk_s2;
	logic signed [PD_W-1:0]    pd_s2;

	// Accumulator store
	logic [ACC_W-1:0]     k_mem  [ACC_DEPTH];
	logic [ACC_W-1:0]     dk_mem [ACC_DEPTH];
	logic [ACC_DEPTH-1:0] vld_q;
	logic [ACC_W-1:0]     rdk_q, rddk_q;

	// Emit counter
	logic [IDX_W-1:0] row_q, col_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [NORM_W-1:0] nk, nm;
	logic signed [RS_W-1:0]   rs;
	logic signed [INT_W-1:0]  interp;
	logic [SLOT_W-1:0]        item_slot, emit_slot, rd_slot;
	logic [ACC_W-1:0]         k_sum, dk_sum;

	// Capture the item at acceptance
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q  <= last_element;
			idx_i_q <= idx_i;
			idx_l_q <= idx_l;
			idx_k_q <= idx_k;
			idx_m_q <= idx_m;
			alpha_q <= stiff_alpha;
			beta_q  <= stiff_beta;
			nx_q    <= normal_x;
			ny_q    <= normal_y;
			nz_q    <= normal_z;
			frac_q  <= phase_fraction;
		end
	end

	assign sts.in_range = (idx_i_q < DIM_IDX) && (idx_l_q < DIM_IDX) &&
	                      (idx_k_q < DIM_IDX) && (idx_m_q < DIM_IDX);
	assign sts.last      = last_q;
	assign sts.emit_done = (row_q == LAST_IDX) && (col_q == LAST_IDX);

	// Select normal components
	always_comb begin
		case (idx_k_q)
			2'd0:    nk = nx_q;
			2'd1:    nk = ny_q;
			2'd2:    nk = nz_q;
			default: nk = '0;
		endcase
		case (idx_m_q)
			2'd0:    nm = nx_q;
			2'd1:    nm = ny_q;
			2'd2:    nm = nz_q;
			default: nm = '0;
		endcase
	end

	assign diff = DIFF_W'(alpha_q) - DIFF_W'(beta_q);

	// First product stage: weighted difference and normal pair
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			hd_s1   <= $signed({1'b0, frac_q}) * diff;
			nn_s1   <= nk * nm;
			diff_s1 <= diff;
			beta_s1 <= beta_q;
		end
	end

	// Round half up the weighted difference, then interpolate
	assign rs     = RS_W'(hd_s1 >>> INTERP_SHIFT) + RS_W'(hd_s1[INTERP_SHIFT-1]);
	assign interp = INT_W'(beta_s1) + INT_W'(rs);

	// Second product stage: contraction with the normal pair
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			pk_s2 <= nn_s1 * interp;
			pd_s2 <= nn_s1 * diff_s1;
		end
	end

	assign item_slot = SLOT_W'(idx_i_q) * SLOT_W'(ACC_ROWS) + SLOT_W'(idx_l_q);
	assign emit_slot = SLOT_W'(row_q) * SLOT_W'(ACC_ROWS) + SLOT_W'(col_q);
	assign rd_slot   = cmd.emit_rd ? emit_slot : item_slot;

	// Read an accumulator slot; an invalid entry reads as zero
	always_ff @(posedge clk) begin
		if (cmd.mul2 || cmd.emit_rd) begin
			rdk_q  <= vld_q[rd_slot] ? k_mem[rd_slot]  : '0;
			rddk_q <= vld_q[rd_slot] ? dk_mem[rd_slot] : '0;
		end
	end

	assign k_sum  = rdk_q  + ACC_W'(pk_s2);
	assign dk_sum = rddk_q + ACC_W'(pd_s2);

	// Write back updated accumulators
	always_ff @(posedge clk) begin
		if (cmd.acc_wr) begin
			k_mem[item_slot]  <= k_sum;
			dk_mem[item_slot] <= dk_sum;
		end
	end

	// Clear valid bits on a first item, mark written slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.load && first_element) begin
			vld_q <= '0;
		end else if (cmd.acc_wr) begin
			vld_q[item_slot] <= 1'b1;
		end
	end

	// Advance the emit counter in row-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.load) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.emit_adv) begin
			if (col_q == LAST_IDX) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Round half up to stiffness units and clamp to the result range
	function automatic logic [VAL_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
		logic [ACC_W-OUT_SHIFT:0] rnd;
		rnd = {acc[ACC_W-1], acc[ACC_W-1:OUT_SHIFT]} +
		      (ACC_W-OUT_SHIFT+1)'(acc[OUT_SHIFT-1]);
		if (rnd[ACC_W-OUT_SHIFT:VAL_W-1] == '0 || rnd[ACC_W-OUT_SHIFT:VAL_W-1] == '1) begin
			return rnd[VAL_W-1:0];
		end else if (rnd[ACC_W-OUT_SHIFT]) begin
			return {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VAL_W-1){1'b1}}};
		end
	endfunction

	// Load result registers
	always_ff @(posedge clk) begin
		if (cmd.emit_cvt) begin
			out_row     <= row_q;
			out_col     <= col_q;
			k_value     <= round_sat(rdk_q);
			dk_value    <= round_sat(rddk_q);
			last_result <= sts.emit_done;
		end
	end

endmodule
